/* src/cltiu_pkg.sv */
// ----------------------------------------------------------------------------
// cltiu_pkg
// Shared types, address map and sizing for the core-local timer interrupt unit.
// ----------------------------------------------------------------------------
package cltiu_pkg;

  // number of harts served
  localparam int unsigned NumCores = 4;
  localparam int unsigned CoreW    = (NumCores > 1) ? $clog2(NumCores) : 1;

  // result vectors always report cores 0 to 3
  localparam int unsigned LevelW = 4;

  // address map
  localparam logic [15:0] SoftBase = 16'h0000;
  localparam logic [15:0] SoftEnd  = 16'(SoftBase + NumCores * 4);
  localparam logic [15:0] CmpBase  = 16'h4000;
  localparam logic [15:0] CmpEnd   = 16'(CmpBase + NumCores * 8);
  localparam logic [15:0] TimeAddr = 16'hBFF8;
  localparam logic [3:0]  TimeSize = 4'd8;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  // item kinds
  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindTick  = 2'd2;

  // decoded target of a bus access
  typedef enum logic [1:0] {
    HIT_SOFT = 2'd0,
    HIT_CMP  = 2'd1,
    HIT_TIME = 2'd2,
    HIT_MISS = 2'd3
  } hit_e;

  typedef struct packed {
    hit_e             hit;
    logic [CoreW-1:0] core;
  } dec_t;

  // registered input beat after address decode
  typedef struct packed {
    logic [1:0]  kind;
    dec_t        dec;
    logic [63:0] write_data;
    logic [63:0] tick_delta;
  } item_t;

  typedef struct packed {
    logic [63:0]       read_data;
    logic              access_error;
    logic [LevelW-1:0] timer_pending;
    logic [LevelW-1:0] software_pending;
  } result_t;

endpackage

/* src/cltiu_decode.sv */
// ----------------------------------------------------------------------------
// cltiu_decode
// Address decode of a bus access into target register and core index.
// ----------------------------------------------------------------------------
module cltiu_decode import cltiu_pkg::*; (
  input  logic [15:0] offset_i,
  input  logic [3:0]  access_size_i,
  output dec_t        dec_o
);

  logic [15:0] soft_idx;
  logic [15:0] cmp_idx;

  // slot index inside each region
  assign soft_idx = (offset_i - SoftBase) >> 2;
  assign cmp_idx  = (offset_i - CmpBase) >> 3;

  // region match, software bits first
  always_comb begin
    dec_o.hit  = HIT_MISS;
    dec_o.core = '0;
    if (offset_i >= SoftBase && offset_i < SoftEnd) begin
      dec_o.hit  = HIT_SOFT;
      dec_o.core = soft_idx[CoreW-1:0];
    end else if (offset_i >= CmpBase && offset_i < CmpEnd) begin
      dec_o.hit  = HIT_CMP;
      dec_o.core = cmp_idx[CoreW-1:0];
    end else if (offset_i == TimeAddr && access_size_i >= TimeSize) begin
      dec_o.hit  = HIT_TIME;
    end
  end

endmodule

/* src/cltiu_state.sv */
// ----------------------------------------------------------------------------
// cltiu_state
// Time counter, per-core compare and software bits, and result formation.
// ----------------------------------------------------------------------------
module cltiu_state import cltiu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  logic [63:0]         time_q, time_d;
  logic [63:0]         cmp_q [NumCores];
  logic [63:0]         cmp_d [NumCores];
  logic [NumCores-1:0] soft_q, soft_d;
  logic                is_read, is_write, is_tick;

  assign is_read  = (item_i.kind == KindRead);
  assign is_write = (item_i.kind == KindWrite);
  assign is_tick  = (item_i.kind == KindTick);

  // next state for this beat
  always_comb begin
    time_d = time_q;
    soft_d = soft_q;
    for (int c = 0; c < NumCores; c++) begin
      cmp_d[c] = cmp_q[c];
    end
    if (is_tick) begin
      time_d = time_q + item_i.tick_delta;
    end else if (is_write) begin
      case (item_i.dec.hit)
        HIT_SOFT: soft_d[item_i.dec.core] = (item_i.write_data != 64'd0);
        HIT_CMP:  cmp_d[item_i.dec.core]  = item_i.write_data;
        HIT_TIME: time_d                  = item_i.write_data;
        default:  ;
      endcase
    end
  end

  // read data, error flag and interrupt levels after this beat, cores 0 to 3
  always_comb begin
    res_o.read_data        = '0;
    res_o.access_error     = 1'b0;
    res_o.timer_pending    = '0;
    res_o.software_pending = '0;
    if (is_read || is_write) begin
      case (item_i.dec.hit)
        HIT_SOFT: if (is_read) res_o.read_data = {63'd0, soft_q[item_i.dec.core]};
        HIT_CMP:  if (is_read) res_o.read_data = cmp_q[item_i.dec.core];
        HIT_TIME: if (is_read) res_o.read_data = time_q;
        default:  res_o.access_error = 1'b1;
      endcase
    end
    for (int c = 0; c < NumCores && c < LevelW; c++) begin
      res_o.timer_pending[c]    = (time_d >= cmp_d[c]);
      res_o.software_pending[c] = soft_d[c];
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      soft_q <= '0;
      for (int c = 0; c < NumCores; c++) begin
        cmp_q[c] <= AllOnes;
      end
    end else if (fire_i) begin
      time_q <= time_d;
      soft_q <= soft_d;
      for (int c = 0; c < NumCores; c++) begin
        cmp_q[c] <= cmp_d[c];
      end
    end
  end

  // a missed access leaves the time counter and software bits alone
  a_miss_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.access_error |=> $stable(time_q) && $stable(soft_q))
    else $error("missed access changed state");

  // a read never changes the time counter
  a_read_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_read |=> $stable(time_q))
    else $error("read changed time counter");

endmodule

/* src/core_local_timer_interrupt_unit.sv */
// Flow: a beat accepted into the input register moves on to the result register
// when that slot is free or drains. Throughput: one beat per cycle unless the output
// stalls; the state update and the time compares are combinational between the
// input register and the result register. Reset: time counter zero, all compares all ones,
// software bits clear, both pipeline stages empty.
// ----------------------------------------------------------------------------
// core_local_timer_interrupt_unit
// Core-local interruptor with time counter, per-core compares and soft bits.
// ----------------------------------------------------------------------------
module core_local_timer_interrupt_unit import cltiu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [15:0]         offset_i,
  input  logic [3:0]          access_size_i,
  input  logic [63:0]         write_data_i,
  input  logic [63:0]         tick_delta_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         read_data_o,
  output logic                access_error_o,
  output logic [LevelW-1:0]   timer_pending_o,
  output logic [LevelW-1:0]   software_pending_o
);

  dec_t    in_dec;
  item_t   item_q;
  logic    item_valid_q;
  logic    advance;
  result_t res_d, res_q;
  logic    res_valid_q;

  // decode ahead of the input register
  cltiu_decode u_decode (
    .offset_i      (offset_i),
    .access_size_i (access_size_i),
    .dec_o         (in_dec)
  );

  // beat moves to the result register when that slot is free or drains
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.kind       <= kind_i;
      item_q.dec        <= in_dec;
      item_q.write_data <= write_data_i;
      item_q.tick_delta <= tick_delta_i;
    end
  end

  // state update and result formation
  cltiu_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = res_valid_q;
  assign read_data_o        = res_q.read_data;
  assign access_error_o     = res_q.access_error;
  assign timer_pending_o    = res_q.timer_pending;
  assign software_pending_o = res_q.software_pending;

  // a beat that moves on always shows up as a result
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("advanced beat produced no result");

  // a held beat stays in the input register while the output stalls
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && res_valid_q && !out_ready_i |=> item_valid_q)
    else $error("stalled beat was dropped");

  // input only blocks when the input register is occupied
  a_ready_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid_q && res_valid_q && !out_ready_i)
    else $error("input blocked without a stall");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the core-local timer interrupt unit against a cycle-free predictor of
// its time counter, per-core compares and software bits. Bus reads, writes
// and timer ticks are queued up front, driven under random gaps and checked
// beat by beat against the predicted read data, error flag and levels.
// ----------------------------------------------------------------------------
module tb_top;
  import cltiu_pkg::*;

  // kind code that the block must treat as a no-op
  localparam logic [1:0] KindSpare = 2'd3;

  typedef struct {
    bit          drain;
    logic [1:0]  kind;
    logic [15:0] offset;
    logic [3:0]  size;
    logic [63:0] wdata;
    logic [63:0] delta;
  } bus_op_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        kind = '0;
  logic [15:0]       offset = '0;
  logic [3:0]        access_size = '0;
  logic [63:0]       write_data = '0;
  logic [63:0]       tick_delta = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [63:0]       read_data;
  logic              access_error;
  logic [LevelW-1:0] timer_pending;
  logic [LevelW-1:0] software_pending;

  // predicted block state
  logic [63:0] time_now;
  logic [63:0] cmp_val [NumCores];
  bit          soft_bit [NumCores];

  bus_op_t bus_ops_q [$];
  result_t irq_reports_q [$];

  int unsigned total_beats = 0;
  int unsigned beats_in = 0;
  int unsigned mismatches = 0;
  bit          in_fire = 1'b0;
  bit          calm = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  core_local_timer_interrupt_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .kind_i             (kind),
    .offset_i           (offset),
    .access_size_i      (access_size),
    .write_data_i       (write_data),
    .tick_delta_i       (tick_delta),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .read_data_o        (read_data),
    .access_error_o     (access_error),
    .timer_pending_o    (timer_pending),
    .software_pending_o (software_pending)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // apply one beat to the predicted state and return its report
  function automatic result_t next_irq_report(input logic [1:0] op_kind,
                                              input logic [15:0] off,
                                              input logic [3:0] size,
                                              input logic [63:0] wdata,
                                              input logic [63:0] delta);
    result_t     r;
    hit_e        hit;
    int unsigned addr;
    int unsigned core;
    addr = 32'(off);
    core = 0;
    hit  = HIT_MISS;
    r    = '0;
    // address decode
    if (addr >= SoftBase && addr < SoftBase + NumCores * 4) begin
      hit  = HIT_SOFT;
      core = (addr - SoftBase) / 4;
    end else if (addr >= CmpBase && addr < CmpBase + NumCores * 8) begin
      hit  = HIT_CMP;
      core = (addr - CmpBase) / 8;
    end else if (off == TimeAddr && size >= TimeSize) begin
      hit = HIT_TIME;
    end
    case (op_kind)
      KindRead: begin
        case (hit)
          HIT_SOFT: r.read_data = {63'd0, soft_bit[core]};
          HIT_CMP:  r.read_data = cmp_val[core];
          HIT_TIME: r.read_data = time_now;
          default:  r.access_error = 1'b1;
        endcase
      end
      KindWrite: begin
        case (hit)
          HIT_SOFT: soft_bit[core] = (wdata != '0);
          HIT_CMP:  cmp_val[core] = wdata;
          HIT_TIME: time_now = wdata;
          default:  r.access_error = 1'b1;
        endcase
      end
      KindTick: time_now = time_now + delta;
      default: ;
    endcase
    // levels after the beat took effect
    for (int c = 0; c < NumCores && c < LevelW; c++) begin
      r.timer_pending[c]    = (time_now >= cmp_val[c]);
      r.software_pending[c] = soft_bit[c];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  task automatic add_op(input logic [1:0] op_kind, input logic [15:0] off,
                        input logic [3:0] size, input logic [63:0] wdata,
                        input logic [63:0] delta);
    bus_ops_q.push_back('{drain: 1'b0, kind: op_kind, offset: off, size: size,
                          wdata: wdata, delta: delta});
    total_beats++;
  endtask

  // small values, values just under all ones, zero, or anything
  function automatic logic [63:0] pick_value(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 64'($urandom_range(0, span));
    if (r < 75) return AllOnes - 64'($urandom_range(0, span));
    if (r < 80) return '0;
    return {$urandom, $urandom};
  endfunction

  // mostly register slots, some boundaries around them, some anything
  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 9))
      0, 1, 2: return SoftBase + 16'($urandom_range(0, NumCores * 4 - 1));
      3, 4, 5: return CmpBase + 16'($urandom_range(0, NumCores * 8 - 1));
      6, 7:    return TimeAddr;
      8: begin
        case ($urandom_range(0, 7))
          0: return SoftEnd;
          1: return CmpBase - 16'd1;
          2: return CmpEnd;
          3: return CmpEnd - 16'd1;
          4: return TimeAddr - 16'd1;
          5: return TimeAddr + 16'd1;
          6: return TimeAddr + 16'd4;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    logic [1:0]  k;
    logic [15:0] off;
    logic [3:0]  sz;
    logic [63:0] wd;
    logic [63:0] dl;
    int unsigned r;
    time_now = '0;
    for (int c = 0; c < NumCores; c++) begin
      cmp_val[c]  = AllOnes;
      soft_bit[c] = 1'b0;
    end

    // directed: reset values, every slot kind, misses, wrap, spare kind
    add_op(KindRead,  TimeAddr,        TimeSize, '0,       '0);
    add_op(KindRead,  SoftBase,        4'd4,     AllOnes,  AllOnes);
    add_op(KindRead,  CmpBase,         4'd8,     '0,       '0);
    add_op(KindWrite, SoftBase + 16'd5, 4'd1,    64'h8000_0000_0000_0000, '0);
    add_op(KindWrite, SoftBase + 16'd8, 4'd4,    '0,       '0);
    add_op(KindWrite, SoftBase + 16'd15, 4'd1,   64'd1,    '0);
    add_op(KindRead,  SoftBase + 16'd4, 4'd4,    '0,       '0);
    add_op(KindRead,  SoftEnd,         4'd4,     '0,       '0);
    add_op(KindWrite, CmpBase,         4'd1,     64'd100,  '0);
    add_op(KindWrite, CmpEnd - 16'd1,  4'd2,     '0,       '0);
    add_op(KindTick,  '0,              '0,       '0,       64'd99);
    add_op(KindTick,  '0,              '0,       '0,       64'd1);
    add_op(KindRead,  CmpEnd - 16'd1,  4'd8,     '0,       '0);
    add_op(KindRead,  TimeAddr,        4'd7,     '0,       '0);
    add_op(KindWrite, TimeAddr,        4'd4,     64'd5,    '0);
    add_op(KindWrite, TimeAddr,        4'd15,    AllOnes,  '0);
    add_op(KindRead,  TimeAddr,        4'd8,     '0,       '0);
    add_op(KindTick,  '0,              '0,       '0,       64'd2);
    add_op(KindRead,  CmpEnd,          4'd8,     '0,       '0);
    add_op(KindWrite, CmpBase - 16'd1, 4'd8,     AllOnes,  '0);
    add_op(KindRead,  TimeAddr + 16'd1, 4'd8,    '0,       '0);
    add_op(KindRead,  16'hFFFF,        4'd0,     '0,       '0);
    add_op(KindSpare, TimeAddr,        4'd8,     AllOnes,  AllOnes);
    add_op(KindTick,  '0,              '0,       '0,       AllOnes);
    bus_ops_q.push_back('{drain: 1'b1, default: '0});

    // random beats biased toward register hits and compares near time
    for (int i = 0; i < 1200; i++) begin
      if (i == 600) bus_ops_q.push_back('{drain: 1'b1, default: '0});
      r  = $urandom_range(0, 99);
      k  = (r < 35) ? KindRead : (r < 75) ? KindWrite : (r < 97) ? KindTick : KindSpare;
      off = pick_offset();
      if ($urandom_range(0, 19) == 0) sz = 4'($urandom_range(0, 15));
      else if (off == TimeAddr)
        sz = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 7)) : TimeSize;
      else sz = 4'($urandom_range(1, 8));
      wd = {$urandom, $urandom};
      if (k == KindWrite && off < SoftEnd)
        wd = ($urandom_range(0, 1) == 0) ? '0 : pick_value(4095);
      else if (k == KindWrite)
        wd = pick_value(4095);
      dl = {$urandom, $urandom};
      if (k == KindTick)
        dl = ($urandom_range(0, 3) == 0) ? pick_value(4095) : 64'($urandom_range(0, 63));
      add_op(k, off, sz, wd, dl);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // all beats taken and every report back
    do @(negedge clk_i);
    while (beats_in != total_beats || irq_reports_q.size() != 0);
    repeat (8) @(negedge clk_i);
    if (irq_reports_q.size() != 0)
      report_mismatch("reports still outstanding", 64'(irq_reports_q.size()), '0);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  // sender: present queued beats with random gaps, hold until taken
  always @(negedge clk_i) begin : drive_ops
    bus_op_t op;
    logic    valid_next;
    int unsigned r;
    if (rst_ni && !(in_valid && !in_fire)) begin
      valid_next = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (bus_ops_q.size() > 0) begin
        if (bus_ops_q[0].drain) begin
          // pause until every outstanding report has come back
          if (irq_reports_q.size() == 0) void'(bus_ops_q.pop_front());
        end else begin
          op = bus_ops_q.pop_front();
          kind        <= op.kind;
          offset      <= op.offset;
          access_size <= op.size;
          write_data  <= op.wdata;
          tick_delta  <= op.delta;
          valid_next  = 1'b1;
          r = $urandom_range(0, 99);
          if (calm || r < 60) send_gap = 0;
          else if (r < 90) send_gap = $urandom_range(1, 3);
          else send_gap = $urandom_range(5, 30);
        end
      end
      in_valid <= valid_next;
    end
  end

  // receiver: random stalls plus one long hold to back the block up
  always @(negedge clk_i) begin : drive_ready
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      if (!long_hold_done && beats_in >= 300) begin
        stall_left     = 80;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 40);
      end
      out_ready <= (stall_left == 0);
    end
  end

  // predict on each input beat, check each output beat
  always @(posedge clk_i) begin : watch
    result_t want;
    in_fire = 1'b0;
    if ($urandom_range(0, 199) == 0) calm = !calm;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        irq_reports_q.push_back(next_irq_report(kind, offset, access_size,
                                                write_data, tick_delta));
        beats_in++;
      end
      if (out_valid && out_ready) begin
        if (irq_reports_q.size() == 0) begin
          report_mismatch("result beat with none pending", read_data, '0);
        end else begin
          want = irq_reports_q.pop_front();
          if (read_data !== want.read_data)
            report_mismatch("read_data", read_data, want.read_data);
          if (access_error !== want.access_error)
            report_mismatch("access_error", 64'(access_error),
                            64'(want.access_error));
          if (timer_pending !== want.timer_pending)
            report_mismatch("timer_pending", 64'(timer_pending),
                            64'(want.timer_pending));
          if (software_pending !== want.software_pending)
            report_mismatch("software_pending", 64'(software_pending),
                            64'(want.software_pending));
        end
      end
    end
  end

endmodule

/* core_local_timer_interrupt_unit.f */
src/cltiu_pkg.sv
src/cltiu_decode.sv
src/cltiu_state.sv
src/core_local_timer_interrupt_unit.sv
verif/tb_top.sv
